// ===== hdl/amag_pkg.sv =====
// Shared types and constants for the accelerometer motion aggregator.
package amag_pkg;

    localparam int TIMER_BITS  = 24;
    localparam int SEC_PER_MIN = 60;
    localparam int SEC_BITS    = 6;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [15:0] TPS_RESET = 16'd32768;

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_EVENT  = 2'd1;
    localparam logic [1:0] REQ_MINUTE = 2'd2;

    typedef struct packed {
        logic [1:0]            req_type;
        logic signed [15:0]    accel_x;
        logic signed [15:0]    accel_y;
        logic signed [15:0]    accel_z;
        logic [TIMER_BITS-1:0] timer_now;
    } t_in_word;

    typedef struct packed {
        logic [31:0]        magnitude_sq;
        logic [31:0]        peak_magnitude;
        logic signed [15:0] mean_x;
        logic signed [15:0] mean_y;
        logic signed [15:0] mean_z;
        logic [15:0]        sample_count;
        logic [63:0]        motion_seconds;
    } t_out_word;

    // Control into one axis lane.
    typedef struct packed {
        logic        start;
        logic        clear;
        logic [15:0] divisor;
    } t_lane_ctl;

    // Control into the elapsed-seconds divider.
    typedef struct packed {
        logic                  start;
        logic [TIMER_BITS-1:0] diff;
        logic [15:0]           tps;
    } t_sec_ctl;

endpackage

// ===== hdl/amag_lane.sv =====
// One axis lane: squares the sample and updates the running mean with a serial divider.
module amag_lane
    import amag_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane_ctl          i_ctl,
    input  logic signed [15:0] i_sample,
    output logic               o_done,
    output logic [31:0]        o_sq,
    output logic signed [15:0] o_mean
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PREP = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;
    localparam int         DIV_STEPS = 17;

    logic [1:0]         r_phase, n_phase;
    logic [4:0]         r_step;
    logic signed [15:0] r_v;
    logic signed [15:0] r_mean;
    logic [15:0]        r_div;
    logic [31:0]        r_sq;
    logic               r_neg;
    logic [15:0]        r_rem;
    logic [16:0]        r_quo;

    logic [16:0] abs_v;
    logic [33:0] sq_full;
    logic [16:0] diff;
    logic [16:0] diff_mag;
    logic [16:0] rem2;
    logic        qbit;
    logic [16:0] rem_sub;
    logic [17:0] delta;
    logic [17:0] mean_sum;

    assign abs_v    = r_v[15] ? (17'd0 - {r_v[15], r_v}) : {1'b0, r_v};
    assign sq_full  = {17'd0, abs_v} * {17'd0, abs_v};
    assign diff     = {r_v[15], r_v} - {r_mean[15], r_mean};
    assign diff_mag = diff[16] ? (17'd0 - diff) : diff;
    assign rem2     = {r_rem, r_quo[16]};
    assign qbit     = rem2 >= {1'b0, r_div};
    assign rem_sub  = rem2 - {1'b0, r_div};
    assign delta    = r_neg ? (18'd0 - {1'b0, r_quo}) : {1'b0, r_quo};
    assign mean_sum = {{2{r_mean[15]}}, r_mean} + delta;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: if (i_ctl.start) n_phase = PH_PREP;
            PH_PREP: n_phase = PH_DIV;
            PH_DIV:  if (r_step == 5'(DIV_STEPS - 1)) n_phase = PH_FIN;
            PH_FIN:  n_phase = PH_IDLE;
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_mean  <= '0;
            r_step  <= '0;
        end else begin
            r_phase <= n_phase;
            if (i_ctl.clear) begin
                r_mean <= '0;
            end
            unique case (r_phase)
                PH_IDLE: begin
                    r_v    <= i_sample;
                    r_div  <= i_ctl.divisor;
                    r_step <= '0;
                end
                PH_PREP: begin
                    r_sq  <= sq_full[31:0];
                    r_neg <= diff[16];
                    r_quo <= diff_mag;
                    r_rem <= '0;
                end
                PH_DIV: begin
                    // Shift one dividend bit into the remainder per cycle.
                    r_rem  <= qbit ? rem_sub[15:0] : rem2[15:0];
                    r_quo  <= {r_quo[15:0], qbit};
                    r_step <= r_step + 5'd1;
                end
                PH_FIN: begin
                    r_mean <= mean_sum[15:0];
                end
                default: ;
            endcase
        end
    end

    assign o_done = (r_phase == PH_FIN);
    assign o_sq   = r_sq;
    assign o_mean = r_mean;

endmodule

// ===== hdl/amag_secdiv.sv =====
// Serial divider for elapsed seconds, folding the quotient modulo one minute.
module amag_secdiv
    import amag_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_sec_ctl            i_ctl,
    output logic                o_done,
    output logic [SEC_BITS-1:0] o_sec
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DIV  = 2'd1;
    localparam logic [1:0] PH_FIN  = 2'd2;
    localparam int         STEP_BITS = $clog2(TIMER_BITS);

    logic [1:0]            r_phase, n_phase;
    logic [STEP_BITS-1:0]  r_step;
    logic [TIMER_BITS-1:0] r_num;
    logic [15:0]           r_tps;
    logic [15:0]           r_rem;
    logic [SEC_BITS-1:0]   r_mod;

    logic [16:0]         rem2;
    logic                qbit;
    logic [16:0]         rem_sub;
    logic [SEC_BITS:0]   mod2;
    logic [SEC_BITS:0]   mod_next;

    assign rem2     = {r_rem, r_num[TIMER_BITS-1]};
    assign qbit     = rem2 >= {1'b0, r_tps};
    assign rem_sub  = rem2 - {1'b0, r_tps};
    assign mod2     = {r_mod, qbit};
    // Quotient arrives MSB first: fold it into seconds mod 60 as it goes.
    assign mod_next = (mod2 >= (SEC_BITS + 1)'(SEC_PER_MIN))
                    ? mod2 - (SEC_BITS + 1)'(SEC_PER_MIN) : mod2;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: if (i_ctl.start) n_phase = PH_DIV;
            PH_DIV:  if (r_step == STEP_BITS'(TIMER_BITS - 1)) n_phase = PH_FIN;
            PH_FIN:  n_phase = PH_IDLE;
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_step  <= '0;
        end else begin
            r_phase <= n_phase;
            unique case (r_phase)
                PH_IDLE: begin
                    r_num  <= i_ctl.diff;
                    // Treat a zero rate as one tick per second.
                    r_tps  <= (i_ctl.tps == 16'd0) ? 16'd1 : i_ctl.tps;
                    r_rem  <= '0;
                    r_mod  <= '0;
                    r_step <= '0;
                end
                PH_DIV: begin
                    r_rem  <= qbit ? rem_sub[15:0] : rem2[15:0];
                    r_num  <= {r_num[TIMER_BITS-2:0], 1'b0};
                    r_mod  <= mod_next[SEC_BITS-1:0];
                    r_step <= r_step + STEP_BITS'(1);
                end
                default: ;
            endcase
        end
    end

    assign o_done = (r_phase == PH_FIN);
    assign o_sec  = r_mod;

endmodule

// ===== hdl/accel_motion_aggregator_unit.sv =====
// Top level of the accelerometer motion aggregator: lanes, seconds divider, merge and output.
//
//  channel | valid        | stall        | word
//  --------+--------------+--------------+--------------
//  input   | i_in_valid   | o_in_stall   | i_in_word
//  output  | o_out_valid  | i_out_stall  | o_out_word
//  config  | i_cfg_we     | (none)       | i_cfg_wdata
//
// A sample word runs a prep phase and a 17-step serial divide in each axis lane,
// side by side, before its result goes to the push state. A motion word waits
// on the 24-step seconds divider. Minute-start and unused codes go straight to
// the push state. One word is in work at a time; the next is accepted once the
// result sits in the output register, even while that register is stalled.
// Reset is synchronous and clears all frame state; ticks_per_second resets to 32768.
module accel_motion_aggregator_unit
    import amag_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SAMPLE = 2'd1;
    localparam logic [1:0] ST_EVENT  = 2'd2;
    localparam logic [1:0] ST_PUSH   = 2'd3;

    logic [1:0]            r_state;
    logic [15:0]           r_tps;
    logic [31:0]           r_mag;
    logic [31:0]           r_peak;
    logic [15:0]           r_count;
    logic [63:0]           r_mask;
    logic [TIMER_BITS-1:0] r_anchor;
    logic                  r_out_valid;
    t_out_word             r_out_word;

    logic                  accept;
    logic                  out_free;
    logic [15:0]           count_inc;
    t_lane_ctl             lane_ctl;
    t_sec_ctl              sec_ctl;
    logic                  done_x, done_y, done_z;
    logic [31:0]           sq_x, sq_y, sq_z;
    logic signed [15:0]    mean_x, mean_y, mean_z;
    logic [31:0]           mag_sum;
    logic                  sec_done;
    logic [SEC_BITS-1:0]   sec_bit;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign count_inc  = (r_count == COUNT_MAX) ? r_count : r_count + 16'd1;

    assign lane_ctl.start   = accept && (i_in_word.req_type == REQ_SAMPLE);
    assign lane_ctl.clear   = accept && (i_in_word.req_type == REQ_MINUTE);
    assign lane_ctl.divisor = count_inc;

    assign sec_ctl.start = accept && (i_in_word.req_type == REQ_EVENT);
    assign sec_ctl.diff  = i_in_word.timer_now - r_anchor;
    assign sec_ctl.tps   = r_tps;

    amag_lane u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_sample (i_in_word.accel_x),
        .o_done   (done_x),
        .o_sq     (sq_x),
        .o_mean   (mean_x)
    );

    amag_lane u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_sample (i_in_word.accel_y),
        .o_done   (done_y),
        .o_sq     (sq_y),
        .o_mean   (mean_y)
    );

    amag_lane u_lane_z (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_sample (i_in_word.accel_z),
        .o_done   (done_z),
        .o_sq     (sq_z),
        .o_mean   (mean_z)
    );

    amag_secdiv u_secdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sec_ctl),
        .o_done  (sec_done),
        .o_sec   (sec_bit)
    );

    // Merge the lane squares; each is at most 2^30, so the sum fits 32 bits.
    assign mag_sum = sq_x + sq_y + sq_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tps       <= TPS_RESET;
            r_peak      <= '0;
            r_count     <= '0;
            r_mask      <= '0;
            r_anchor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tps <= i_cfg_wdata;
            end
            // Load a finished word, or drop the one just taken.
            if (out_free) begin
                r_out_valid <= (r_state == ST_PUSH);
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_mag <= '0;
                        unique case (i_in_word.req_type)
                            REQ_SAMPLE: begin
                                r_count <= count_inc;
                                r_state <= ST_SAMPLE;
                            end
                            REQ_EVENT: r_state <= ST_EVENT;
                            REQ_MINUTE: begin
                                r_peak   <= '0;
                                r_count  <= '0;
                                r_mask   <= '0;
                                r_anchor <= i_in_word.timer_now;
                                r_state  <= ST_PUSH;
                            end
                            default: r_state <= ST_PUSH;
                        endcase
                    end
                end
                ST_SAMPLE: begin
                    if (done_x && done_y && done_z) begin
                        r_mag <= mag_sum;
                        if (r_peak < mag_sum) begin
                            r_peak <= mag_sum;
                        end
                        r_state <= ST_PUSH;
                    end
                end
                ST_EVENT: begin
                    if (sec_done) begin
                        r_mask  <= r_mask | (64'd1 << sec_bit);
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    // Hold until the output register can take the word.
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PUSH && out_free) begin
            r_out_word.magnitude_sq   <= r_mag;
            r_out_word.peak_magnitude <= r_peak;
            r_out_word.mean_x         <= mean_x;
            r_out_word.mean_y         <= mean_y;
            r_out_word.mean_z         <= mean_z;
            r_out_word.sample_count   <= r_count;
            r_out_word.motion_seconds <= r_mask;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
